### src/dab_packet_mode_deframer_top_macros.svh
// assertion helpers shared by the deframer modules
`ifndef DAB_PACKET_MODE_DEFRAMER_TOP_MACROS_SVH
`define DAB_PACKET_MODE_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DABPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define DABPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### src/dabpm_pkg.sv
package dabpm_pkg;

    localparam int CFG_W = 21;

    // configuration register indexes
    localparam logic REG_PACKET_ADDRESS = 1'b0;
    localparam logic REG_GROUP_LIMIT    = 1'b1;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [2:0]  NONE_EXPECTED = 3'd4;
    localparam logic [20:0] LIMIT_RESET   = 21'd1048576;

    typedef enum logic [3:0] {
        VERDICT_CRC_BAD        = 4'd0,
        VERDICT_ADDR_MISMATCH  = 4'd1,
        VERDICT_COMMAND        = 4'd2,
        VERDICT_BAD_USEFUL_LEN = 4'd3,
        VERDICT_SINGLE_GROUP   = 4'd4,
        VERDICT_GROUP_START    = 4'd5,
        VERDICT_START_OVERSIZE = 4'd6,
        VERDICT_CONTINUED      = 4'd7,
        VERDICT_GROUP_DONE     = 4'd8,
        VERDICT_CONT_BREAK     = 4'd9,
        VERDICT_OVERFLOW       = 4'd10
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [6:0]  useful_length;
        logic [1:0]  continuity;
        logic [20:0] group_length;
    } out_item_t;

    // packet facts handed from the framer to the judge
    typedef struct packed {
        logic       done;
        logic       crc_ok;
        logic [1:0] ci;
        logic [1:0] fl;
        logic [9:0] addr;
        logic       cmd;
        logic [6:0] useful;
        logic [6:0] useful_max;
    } pkt_info_t;

    function automatic logic [6:0] pkt_last_index(input logic [1:0] code);
        logic [6:0] r;
        unique case (code)
            2'd0: r = 7'd23;
            2'd1: r = 7'd47;
            2'd2: r = 7'd71;
            2'd3: r = 7'd95;
            default: r = 7'd23;
        endcase
        return r;
    endfunction

    // crc-16 ccitt, one byte msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### src/dab_packet_mode_deframer_top.sv
// a byte request is registered in the input register, then judged into the result register
// throughput: one byte per cycle unless a stalled verdict holds the bytes, one verdict on
// the last byte of every complete packet; rate set by the combinational crc byte step and
// header/group logic between the two registers
// reset: asynchronous active low; clears byte position, group state, address 0, limit 1048576
module dab_packet_mode_deframer_top
    import dabpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // byte stream
    input  logic             byte_valid,
    output logic             byte_ready,
    input  in_item_t         byte_item,
    // verdicts
    output logic             verdict_valid,
    input  logic             verdict_ready,
    output out_item_t        verdict_item,
    // configuration writes
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

`include "dab_packet_mode_deframer_top_macros.svh"

    // input register holding one byte request
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;

    // result register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      byte_accept;
    logic      advance;
    pkt_info_t info;
    out_item_t result;

    // the held byte moves on when the result slot is free or being emptied;
    // bytes that end no packet still wait behind a stalled verdict so order holds
    assign advance     = s1_valid_reg && (!out_valid_reg || verdict_ready);
    assign byte_ready  = !s1_valid_reg || advance;
    assign byte_accept = byte_valid && byte_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (byte_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && info.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_item_reg <= byte_item;
        end
        if (advance && info.done)
        begin
            out_item_reg <= result;
        end
    end

    // byte position, crc and header capture
    dabpm_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .info    (info)
    );

    // filtering and data-group tracking
    dabpm_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .info      (info),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    assign verdict_valid = out_valid_reg;
    assign verdict_item  = out_item_reg;

    `DABPM_ASSERT_NEXT(a_done_gives_verdict, clk, rst_n, advance && info.done, out_valid_reg)
    `DABPM_ASSERT_NEXT(a_verdict_range, clk, rst_n, advance && info.done,
                       out_item_reg.verdict <= VERDICT_OVERFLOW)
    `DABPM_ASSERT_IMPL(a_no_advance_when_stalled, clk, rst_n,
                       out_valid_reg && !verdict_ready, !advance)

endmodule

### src/dabpm_frame.sv
module dabpm_frame
    import dabpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  in_item_t   item,
    output pkt_info_t  info
);

`include "dab_packet_mode_deframer_top_macros.svh"

    logic [6:0]  idx_reg, idx_next;
    logic [1:0]  size_reg, size_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  tail_reg;
    logic [23:0] hdr_reg, hdr_next;

    logic        first;
    logic [1:0]  code;
    logic [6:0]  last_idx;
    logic [15:0] crc_base;
    logic [23:0] hdr_base;

    always_comb
    begin
        first    = (idx_reg == 7'd0);
        code     = first ? item.data_byte[7:6] : size_reg;
        last_idx = pkt_last_index(code);
        crc_base = first ? CRC_INIT : crc_reg;
        hdr_base = first ? 24'd0 : hdr_reg;
        size_next = code;

        // crc covers all but the two check bytes
        crc_next = (idx_reg < last_idx - 7'd1) ? crc_byte(crc_base, item.data_byte) : crc_base;
        hdr_next = (idx_reg < 7'd3) ? {hdr_base[15:0], item.data_byte} : hdr_base;

        info.done       = (idx_reg == last_idx);
        info.crc_ok     = ({tail_reg, item.data_byte} == ~crc_reg);
        info.ci         = hdr_reg[21:20];
        info.fl         = hdr_reg[19:18];
        info.addr       = {hdr_reg[17:16], hdr_reg[15:8]};
        info.cmd        = hdr_reg[7];
        info.useful     = hdr_reg[6:0];
        info.useful_max = last_idx - 7'd4;

        if (info.done || item.frame_last)
        begin
            idx_next = 7'd0;
        end
        else
        begin
            idx_next = idx_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 7'd0;
            size_reg <= 2'd0;
        end
        else if (advance)
        begin
            idx_reg  <= idx_next;
            size_reg <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            crc_reg  <= crc_next;
            tail_reg <= item.data_byte;
            hdr_reg  <= hdr_next;
        end
    end

    `DABPM_ASSERT_IMPL(a_idx_range, clk, rst_n, 1'b1, idx_reg <= 7'd95)
    `DABPM_ASSERT_NEXT(a_idx_wrap, clk, rst_n, advance && info.done, idx_reg == 7'd0)
    `DABPM_ASSERT_IMPL(a_idx_in_packet, clk, rst_n, idx_reg != 7'd0,
                       idx_reg <= pkt_last_index(size_reg))

endmodule

### src/dabpm_judge.sv
module dabpm_judge
    import dabpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  pkt_info_t        info,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output out_item_t        result
);

`include "dab_packet_mode_deframer_top_macros.svh"

    logic        active_reg, active_next;
    logic [2:0]  exp_reg, exp_next;
    logic [20:0] count_reg, count_next;
    logic [9:0]  addr_reg;
    logic [20:0] limit_reg;

    logic [21:0] sum;
    logic        overflow;
    logic        start_fits;
    logic [2:0]  exp_after;
    verdict_t    verdict;
    logic [20:0] glen;

    always_comb
    begin
        sum        = {1'b0, count_reg} + {15'd0, info.useful};
        overflow   = sum > {1'b0, limit_reg};
        start_fits = {14'd0, info.useful} <= limit_reg;
        exp_after  = {1'b0, info.ci + 2'd1};

        active_next = active_reg;
        exp_next    = exp_reg;
        count_next  = count_reg;
        glen        = count_reg;
        verdict     = VERDICT_CRC_BAD;

        priority if (!info.crc_ok)
        begin
            verdict = VERDICT_CRC_BAD;
        end
        else if (info.addr == 10'd0 || info.addr != addr_reg)
        begin
            verdict = VERDICT_ADDR_MISMATCH;
        end
        else if (info.cmd)
        begin
            verdict = VERDICT_COMMAND;
        end
        else if (info.useful > info.useful_max)
        begin
            verdict = VERDICT_BAD_USEFUL_LEN;
        end
        else if (info.fl == 2'd3)
        begin
            verdict     = VERDICT_SINGLE_GROUP;
            glen        = {14'd0, info.useful};
            active_next = 1'b0;
            count_next  = 21'd0;
            exp_next    = exp_after;
        end
        else if (info.fl == 2'd2)
        begin
            verdict     = start_fits ? VERDICT_GROUP_START : VERDICT_START_OVERSIZE;
            count_next  = {14'd0, info.useful};
            glen        = {14'd0, info.useful};
            active_next = start_fits;
            exp_next    = exp_after;
        end
        else if (!active_reg || exp_reg != {1'b0, info.ci})
        begin
            verdict     = VERDICT_CONT_BREAK;
            active_next = 1'b0;
            count_next  = 21'd0;
            exp_next    = NONE_EXPECTED;
            glen        = 21'd0;
        end
        else if (overflow)
        begin
            verdict     = VERDICT_OVERFLOW;
            active_next = 1'b0;
            count_next  = 21'd0;
            exp_next    = exp_after;
            glen        = 21'd0;
        end
        else if (info.fl == 2'd1)
        begin
            verdict     = VERDICT_GROUP_DONE;
            glen        = sum[20:0];
            active_next = 1'b0;
            count_next  = 21'd0;
            exp_next    = exp_after;
        end
        else
        begin
            verdict    = VERDICT_CONTINUED;
            glen       = sum[20:0];
            count_next = sum[20:0];
            exp_next   = exp_after;
        end

        result.verdict       = verdict;
        result.useful_length = info.useful;
        result.continuity    = info.ci;
        result.group_length  = glen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            exp_reg    <= NONE_EXPECTED;
            count_reg  <= 21'd0;
        end
        else if (advance && info.done)
        begin
            active_reg <= active_next;
            exp_reg    <= exp_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= 10'd0;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PACKET_ADDRESS: addr_reg  <= cfg_data[9:0];
                REG_GROUP_LIMIT:    limit_reg <= cfg_data[20:0];
                default:            addr_reg  <= addr_reg;
            endcase
        end
    end

    `DABPM_ASSERT_IMPL(a_active_expects, clk, rst_n, active_reg, exp_reg != NONE_EXPECTED)
    `DABPM_ASSERT_IMPL(a_exp_range, clk, rst_n, 1'b1, exp_reg <= NONE_EXPECTED)
    `DABPM_ASSERT_NEXT(a_idle_hold, clk, rst_n, !(advance && info.done),
                       $stable(count_reg) && $stable(active_reg))

endmodule
